FILE: sv/sacache_pkg.sv
// Shared request type and helper function of the set-associative write-back cache tag store.
package sacache_pkg;

    typedef enum logic {
        REQ_READ  = 1'b0,
        REQ_WRITE = 1'b1
    } t_req;

    function automatic int idx_bits(input int n);
        int w;
        w = (n > 1) ? $clog2(n) : 1;
        return w;
    endfunction

endpackage

FILE: sv/set_assoc_cache_lru_writeback.sv
// Top level: set-associative write-back write-allocate cache tag store with true LRU.
//
//  channel   handshake              payload
//  --------  ---------------------  ----------------------------------------------
//  request   start, busy            i_req_type, i_access_addr
//  result    o_valid (strobe)       o_hit, o_writeback_valid, o_writeback_addr
//
// One item per cycle while busy is low; the set row is read from the RAM as the item is taken,
// then lookup, LRU update and row write-back run and the result is registered onto o_valid.
// A same-set item right behind another takes the written row by forwarding.
// After reset, busy stays high while the set RAM is cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
module set_assoc_cache_lru_writeback
    import sacache_pkg::*;
#(
    parameter int NUM_SETS   = 256,
    parameter int NUM_WAYS   = 4,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_req_type,
    input  logic [ADDR_BITS-1:0]  i_access_addr,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic                  o_writeback_valid,
    output logic [ADDR_BITS-1:0]  o_writeback_addr
);

    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int IDX_W = $clog2(NUM_SETS);
    localparam int TAG_W = ADDR_BITS - OFF_W - IDX_W;
    localparam int AGE_W = idx_bits(NUM_WAYS);
    localparam int WAY_W = idx_bits(NUM_WAYS);
    localparam logic [AGE_W-1:0] OLDEST = AGE_W'(NUM_WAYS - 1);
    localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(NUM_SETS - 1);

    typedef struct packed {
        logic                 valid;
        logic                 dirty;
        logic [AGE_W-1:0]     age;
        logic [TAG_W-1:0]     tag;
        logic [ADDR_BITS-1:0] fill;
    } t_way;

    typedef t_way [NUM_WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    logic                 accept;
    logic                 r_clearing;
    logic [IDX_W-1:0]     r_clr_idx;
    logic                 r_s1_valid;
    logic                 r_s1_write;
    logic [ADDR_BITS-1:0] r_s1_addr;
    logic                 r_fwd_valid;
    logic [IDX_W-1:0]     r_fwd_set;
    t_row                 r_fwd_row;
    logic                 r_valid;
    logic                 r_hit;
    logic                 r_wb_valid;
    logic [ADDR_BITS-1:0] r_wb_addr;

    logic [ROW_W-1:0]     ram_rdata;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;

    logic [IDX_W-1:0]     s1_set;
    logic [TAG_W-1:0]     s1_tag;
    t_row                 cur;
    t_row                 n_row;
    logic [NUM_WAYS-1:0]  hit_vec;
    logic                 s1_hit;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     inv_way;
    logic                 any_inv;
    logic [WAY_W-1:0]     lru_way;
    logic [WAY_W-1:0]     sel_way;
    logic [AGE_W-1:0]     old_age;
    logic                 n_wb_valid;
    logic [ADDR_BITS-1:0] n_wb_addr;

    assign accept = start && !busy;
    assign busy   = r_clearing;

    assign s1_set = r_s1_addr[OFF_W +: IDX_W];
    assign s1_tag = r_s1_addr[ADDR_BITS-1 -: TAG_W];

    sacache_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (i_access_addr[OFF_W +: IDX_W]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        cur = (r_fwd_valid && r_fwd_set == s1_set) ? r_fwd_row : t_row'(ram_rdata);

        hit_vec = '0;
        for (int j = 0; j < NUM_WAYS; j++) begin
            hit_vec[j] = cur[j].valid && (cur[j].tag == s1_tag);
        end
        s1_hit = |hit_vec;

        hit_way = '0;
        inv_way = '0;
        any_inv = 1'b0;
        lru_way = '0;
        for (int j = NUM_WAYS - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                hit_way = WAY_W'(j);
            end
            if (!cur[j].valid) begin
                inv_way = WAY_W'(j);
                any_inv = 1'b1;
            end
            if (cur[j].age == OLDEST) begin
                lru_way = WAY_W'(j);
            end
        end

        if (s1_hit) begin
            sel_way = hit_way;
            old_age = cur[hit_way].age;
        end else if (any_inv) begin
            sel_way = inv_way;
            old_age = OLDEST;
        end else begin
            sel_way = lru_way;
            old_age = OLDEST;
        end

        n_wb_valid = !s1_hit && !any_inv && cur[lru_way].dirty;
        n_wb_addr  = n_wb_valid ? cur[lru_way].fill : '0;

        n_row = cur;
        for (int j = 0; j < NUM_WAYS; j++) begin
            if (WAY_W'(j) == sel_way) begin
                n_row[j].age = '0;
                if (s1_hit) begin
                    n_row[j].dirty = cur[j].dirty || r_s1_write;
                end else begin
                    n_row[j].valid = 1'b1;
                    n_row[j].dirty = r_s1_write;
                    n_row[j].tag   = s1_tag;
                    n_row[j].fill  = r_s1_addr;
                end
            end else if (cur[j].valid && cur[j].age < old_age) begin
                n_row[j].age = cur[j].age + AGE_W'(1);
            end
        end

        ram_we    = r_clearing || r_s1_valid;
        ram_waddr = r_clearing ? r_clr_idx : s1_set;
        ram_wdata = r_clearing ? '0 : ROW_W'(n_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
                if (r_clr_idx == LAST_SET) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1_valid  <= accept;
            r_fwd_valid <= r_s1_valid;
            r_valid     <= r_s1_valid;
        end
        if (accept) begin
            r_s1_write <= (t_req'(i_req_type) == REQ_WRITE);
            r_s1_addr  <= i_access_addr;
        end
        if (r_s1_valid) begin
            r_fwd_set  <= s1_set;
            r_fwd_row  <= n_row;
            r_hit      <= s1_hit;
            r_wb_valid <= n_wb_valid;
            r_wb_addr  <= n_wb_addr;
        end
    end

    assign o_valid           = r_valid;
    assign o_hit             = r_hit;
    assign o_writeback_valid = r_wb_valid;
    assign o_writeback_addr  = r_wb_addr;

    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_valid)
        else $error("accepted item produced no result");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $onehot0(hit_vec))
        else $error("tag matches in more than one way");

    a_wb_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_writeback_valid) |-> !o_hit)
        else $error("writeback reported on a hit");

    a_no_work_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_valid)
        else $error("lookup active during clearing pass");

endmodule

FILE: sv/sacache_ram.sv
// Generic single-write, single-read RAM with registered read data (read returns old data).
module sacache_ram
    import sacache_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [idx_bits(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]            i_wdata,
    input  logic                        i_re,
    input  logic [idx_bits(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the set-associative LRU write-back cache tag store.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sacache_pkg::*;

    localparam int SETS   = 256;
    localparam int WAYS   = 4;
    localparam int OFF_W  = 6;
    localparam int IDX_W  = 8;
    localparam int TAG_W  = 32 - OFF_W - IDX_W;
    localparam int N_RAND = 1550;

    typedef struct packed {
        logic        hit;
        logic        wb_valid;
        logic [31:0] wb_addr;
    } cache_result_t;

    typedef struct packed {
        t_req          req;
        logic [31:0]   addr;
        logic          typed;
        cache_result_t res;
    } access_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_req_type;
    logic [31:0] i_access_addr;
    logic        o_valid;
    logic        o_hit;
    logic        o_writeback_valid;
    logic [31:0] o_writeback_addr;

    // typed expectation travelling with the item on the request side
    logic          use_typed;
    cache_result_t typed_res;

    logic             line_ok    [SETS][WAYS];
    logic             line_dirty [SETS][WAYS];
    logic [TAG_W-1:0] line_tag   [SETS][WAYS];
    logic [31:0]      line_fill  [SETS][WAYS];
    logic [1:0]       line_age   [SETS][WAYS];

    cache_result_t pending_results[$];
    int            mismatch_count;

    access_row_t directed_rows [17] = '{
        '{REQ_READ,  32'h0000_0000, 1'b1, '{1'b0, 1'b0, 32'h0}},
        '{REQ_READ,  32'h0000_0000, 1'b1, '{1'b1, 1'b0, 32'h0}},
        '{REQ_WRITE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'h0}},
        '{REQ_WRITE, 32'h0000_3FC5, 1'b1, '{1'b0, 1'b0, 32'h0}},
        '{REQ_READ,  32'h0000_7FC0, 1'b0, '0},
        '{REQ_READ,  32'h0000_BFC0, 1'b0, '0},
        '{REQ_READ,  32'h0000_3FC0, 1'b1, '{1'b1, 1'b0, 32'h0}},
        '{REQ_READ,  32'h0000_FFC0, 1'b1, '{1'b0, 1'b1, 32'hFFFF_FFFF}},
        '{REQ_READ,  32'h0001_3FC0, 1'b0, '0},
        '{REQ_READ,  32'h0001_7FC0, 1'b0, '0},
        '{REQ_READ,  32'h0001_BFC0, 1'b0, '0},
        '{REQ_WRITE, 32'h0000_0004, 1'b1, '{1'b1, 1'b0, 32'h0}},
        '{REQ_WRITE, 32'h8000_0000, 1'b0, '0},
        '{REQ_WRITE, 32'h4000_0000, 1'b0, '0},
        '{REQ_WRITE, 32'hC000_003F, 1'b0, '0},
        '{REQ_READ,  32'h2000_0000, 1'b1, '{1'b0, 1'b1, 32'h0}},
        '{REQ_WRITE, 32'h7FFF_FFC0, 1'b0, '0}
    };

    set_assoc_cache_lru_writeback u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_access_addr     (i_access_addr),
        .o_valid           (o_valid),
        .o_hit             (o_hit),
        .o_writeback_valid (o_writeback_valid),
        .o_writeback_addr  (o_writeback_addr)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void clear_tags();
        for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
                line_ok[s][w]    = 1'b0;
                line_dirty[s][w] = 1'b0;
                line_tag[s][w]   = '0;
                line_fill[s][w]  = '0;
                line_age[s][w]   = '0;
            end
        end
    endfunction

    function automatic cache_result_t predict_access(input t_req req, input logic [31:0] addr);
        cache_result_t    r;
        logic [IDX_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        int               way;
        int               old_age;
        int               w;
        r       = '0;
        set_idx = addr[OFF_W +: IDX_W];
        tag     = addr[31 -: TAG_W];
        way     = -1;
        for (w = 0; w < WAYS; w++) begin
            if (way < 0 && line_ok[set_idx][w] && line_tag[set_idx][w] == tag) way = w;
        end
        if (way >= 0) begin
            r.hit = 1'b1;
            if (req == REQ_WRITE) line_dirty[set_idx][way] = 1'b1;
            old_age = line_age[set_idx][way];
        end else begin
            for (w = 0; w < WAYS; w++) begin
                if (way < 0 && !line_ok[set_idx][w]) way = w;
            end
            if (way < 0) begin
                way = 0;
                for (w = 1; w < WAYS; w++) begin
                    if (line_age[set_idx][w] > line_age[set_idx][way]) way = w;
                end
                if (line_dirty[set_idx][way]) begin
                    r.wb_valid = 1'b1;
                    r.wb_addr  = line_fill[set_idx][way];
                end
            end
            old_age                  = WAYS - 1;
            line_ok[set_idx][way]    = 1'b1;
            line_tag[set_idx][way]   = tag;
            line_fill[set_idx][way]  = addr;
            line_dirty[set_idx][way] = (req == REQ_WRITE);
        end
        for (w = 0; w < WAYS; w++) begin
            if (w != way && line_ok[set_idx][w] && line_age[set_idx][w] < old_age)
                line_age[set_idx][w] = line_age[set_idx][w] + 2'd1;
        end
        line_age[set_idx][way] = '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cache_result_t want;
        cache_result_t pred;
        if (i_rst_n === 1'b1) begin
            if (o_valid !== 1'b0) begin
                if (pending_results.size() == 0) begin
                    $error("result with no pending access: hit=%0b wb=%0b addr=%h",
                           o_hit, o_writeback_valid, o_writeback_addr);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0b, got %0b", want.hit, o_hit);
                        mismatch_count++;
                    end
                    if (o_writeback_valid !== want.wb_valid) begin
                        $error("writeback_valid: expected %0b, got %0b",
                               want.wb_valid, o_writeback_valid);
                        mismatch_count++;
                    end
                    if (o_writeback_addr !== want.wb_addr) begin
                        $error("writeback_addr: expected %h, got %h",
                               want.wb_addr, o_writeback_addr);
                        mismatch_count++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                pred = predict_access(t_req'(i_req_type), i_access_addr);
                pending_results.push_back(use_typed ? typed_res : pred);
            end
        end
    end

    task automatic send_access(input t_req req, input logic [31:0] addr,
                               input logic has_typed, input cache_result_t typed);
        @(negedge i_clk);
        start         <= 1'b1;
        i_req_type    <= req;
        i_access_addr <= addr;
        use_typed     <= has_typed;
        typed_res     <= typed;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start         <= 1'b0;
            i_req_type    <= 1'($urandom);
            i_access_addr <= $urandom;
            use_typed     <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [TAG_W-1:0] tag_pool [6];
        logic [IDX_W-1:0] hot_set  [4];
        logic [31:0]      addr;
        logic [31:0]      last_addr;
        int               sel;
        mismatch_count = 0;
        clear_tags();
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req_type    = REQ_READ;
        i_access_addr = '0;
        use_typed     = 1'b0;
        typed_res     = '0;
        last_addr     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if ($urandom_range(0, 99) < 36) idle_cycles($urandom_range(1, 3));
            send_access(directed_rows[k].req, directed_rows[k].addr,
                        directed_rows[k].typed, directed_rows[k].res);
        end
        wait_drained();

        for (int n = 0; n < N_RAND; n++) begin
            if (n % 200 == 0) begin
                foreach (tag_pool[k]) tag_pool[k] = TAG_W'($urandom);
                foreach (hot_set[k]) hot_set[k] = IDX_W'($urandom);
            end
            if (n % 400 == 399) wait_drained();
            // no idling in the middle stretch, so same-set items land back to back
            if (n < 500 || n >= 800) begin
                while ($urandom_range(0, 99) < 36) idle_cycles(1);
            end
            sel = $urandom_range(0, 99);
            if (sel < 70)
                addr = {tag_pool[$urandom_range(0, 5)], hot_set[$urandom_range(0, 3)],
                        OFF_W'($urandom)};
            else if (sel < 85)
                addr = $urandom;
            else
                addr = {last_addr[31:OFF_W], OFF_W'($urandom)};
            last_addr = addr;
            send_access(t_req'($urandom_range(0, 1)), addr, 1'b0, '0);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
